### rtl/dscs_pkg.sv
// shared types, constants and crc helpers for the sector crc scrambler
package dscs_pkg;

   // sector geometry
   localparam int unsigned MAX_SECTOR_BYTES = 256;
   localparam int unsigned SD_SECTOR_BYTES  = 128;
   localparam int unsigned HDR_BYTES        = 4;
   localparam int unsigned POS_W            = 9;

   localparam logic [POS_W-1:0] HDR_END     = POS_W'(HDR_BYTES);
   localparam logic [POS_W-1:0] DATA_END_SD = POS_W'(HDR_BYTES + SD_SECTOR_BYTES);
   localparam logic [POS_W-1:0] DATA_END_DD = POS_W'(HDR_BYTES + MAX_SECTOR_BYTES);

   localparam logic [7:0]  SCRAMBLE = 8'hB3;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // command queue between front and back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // csr register indexes
   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_DENSITY   = 1'b1;

   typedef enum logic [1:0] {
      KIND_HDR    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_CRC    = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   // reflected poly 0x8408, one entry per nibble
   localparam logic [15:0] NIB_TABLE [16] = '{
      16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
      16'h8408, 16'h9489, 16'ha50a, 16'hb58b, 16'hc60c, 16'hd68d, 16'he70e, 16'hf78f
   };

   // one command for the back end
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic        ok;
      logic        last;
      logic        tail;   // append crc high and low bytes
      logic [15:0] crc;
   } cmd_type;

   // one result
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       ok;
      logic       last;
   } rsp_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // crc over one byte, low nibble first
   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = {4'h0, crc[15:4]} ^ NIB_TABLE[crc[3:0] ^ b[3:0]];
      c = {4'h0, c[15:4]} ^ NIB_TABLE[c[3:0] ^ b[7:4]];
      return c;
   endfunction

endpackage

### rtl/disk_sector_crc_scrambler.sv
// top level: csr port, front end, command queue and back end
// each byte's command is queued, then its result is registered in the back end
// throughput: one byte per cycle unless req_full; the last encode data byte yields
//   three results, drained one per cycle while popped, as the front takes bytes
// req_full rises when the four-entry command queue fills
// reset: synchronous, clears queue, crc to 0xffff, position, direction 0, density 1
module disk_sector_crc_scrambler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   input  logic        req_first,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_kind,
   output logic        rsp_crc_ok,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dscs_pkg::*;

   logic         direction_ff, density_ff;
   logic         csr_wr, accept, cmd_push, q_pop, rsp_valid;
   cmd_type      cmd, head_cmd;
   q_status_type q_status;
   rsp_type      rsp;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         density_ff   <= 1'b1;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_DIRECTION: direction_ff <= csr_pwdata[0];
            default:       density_ff   <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_DIRECTION: csr_prdata = {31'd0, direction_ff};
         default:       csr_prdata = {31'd0, density_ff};
      endcase
   end

   // input transaction
   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   dscs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_byte_in),
      .first     (req_first),
      .direction (direction_ff),
      .density   (density_ff),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   dscs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   dscs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // result transaction
   assign rsp_empty    = !rsp_valid;
   assign rsp_byte_out = rsp.data;
   assign rsp_kind     = rsp.kind;
   assign rsp_crc_ok   = rsp.ok;
   assign rsp_last     = rsp.last;

endmodule

### rtl/dscs_front.sv
// front end: classifies each byte, runs the crc, issues commands
module dscs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            byte_in,
   input  logic                  first,
   input  logic                  direction,
   input  logic                  density,
   output logic                  cmd_push,
   output dscs_pkg::cmd_type     cmd
);
   import dscs_pkg::*;

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       stored_hi_ff, stored_hi_in;

   logic [15:0]      crc_base, crc_new;
   logic [POS_W-1:0] pos, pos_inc, data_end;
   logic [7:0]       plain;
   logic             issue;

   // restart and sector size
   always_comb begin
      pos      = first ? '0 : pos_ff;
      crc_base = first ? CRC_INIT : crc_ff;
      pos_inc  = pos + POS_W'(1);
      data_end = density ? DATA_END_DD : DATA_END_SD;
      plain    = byte_in ^ SCRAMBLE;
   end

   // classify the byte and build the command
   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      stored_hi_in = stored_hi_ff;
      issue        = 1'b0;
      crc_new      = crc_byte(crc_base, (pos >= HDR_END && direction) ? plain : byte_in);
      cmd          = '{data: byte_in, kind: KIND_HDR, ok: 1'b0, last: 1'b0,
                       tail: 1'b0, crc: crc_new};
      if (pos < HDR_END) begin
         crc_in = crc_new;
         pos_in = pos_inc;
         issue  = 1'b1;
      end else if (pos < data_end) begin
         crc_in    = crc_new;
         pos_in    = pos_inc;
         issue     = 1'b1;
         cmd.kind  = KIND_DATA;
         cmd.data  = direction ? plain : byte_in ^ SCRAMBLE;
         cmd.tail  = !direction && (pos_inc == data_end);
      end else if (direction) begin
         crc_in = crc_base;
         if (pos == data_end) begin
            stored_hi_in = byte_in;
            pos_in       = pos_inc;
         end else if (pos == data_end + POS_W'(1)) begin
            pos_in   = pos_inc;
            issue    = 1'b1;
            cmd.data = '0;
            cmd.kind = KIND_STATUS;
            cmd.ok   = ({stored_hi_ff, byte_in} == crc_base);
            cmd.last = 1'b1;
         end else begin
            pos_in = pos;
         end
      end else begin
         crc_in = crc_base;
         pos_in = pos;
      end
   end

   assign cmd_push = accept && issue;

   // sector state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         pos_ff       <= '0;
         stored_hi_ff <= '0;
      end else if (accept) begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         stored_hi_ff <= stored_hi_in;
      end
   end

endmodule

### rtl/dscs_queue.sv
// short command queue between front and back
module dscs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dscs_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output dscs_pkg::cmd_type      head_cmd,
   output dscs_pkg::q_status_type status
);
   import dscs_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ff];

   // pointers and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/dscs_back.sv
// back end: expands commands into results and holds the output register
module dscs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dscs_pkg::cmd_type      head_cmd,
   input  dscs_pkg::q_status_type q_status,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_valid,
   output dscs_pkg::rsp_type      rsp
);
   import dscs_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       out_free, load, final_phase;

   assign out_free    = !valid_ff || rsp_pop;
   assign load        = !q_status.empty && out_free;
   assign final_phase = !head_cmd.tail || (phase_ff == 2'd2);
   assign q_pop       = load && final_phase;

   // result select by phase
   always_comb begin
      case (phase_ff)
         2'd1:    rsp_in = '{data: head_cmd.crc[15:8], kind: KIND_CRC, ok: 1'b0, last: 1'b0};
         2'd2:    rsp_in = '{data: head_cmd.crc[7:0], kind: KIND_CRC, ok: 1'b0, last: 1'b1};
         default: rsp_in = '{data: head_cmd.data, kind: head_cmd.kind, ok: head_cmd.ok,
                             last: head_cmd.last};
      endcase
      phase_in = phase_ff;
      if (load) begin
         phase_in = final_phase ? 2'd0 : phase_ff + 2'd1;
      end
      valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/dscs_checker.sv
// port checker for the sector crc scrambler and its bind
module dscs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_byte_out,
   input logic [1:0]  rsp_kind,
   input logic        rsp_crc_ok,
   input logic        rsp_last
);
   import dscs_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_byte_out)
                                    && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("waiting result changed");

   // status result is zero byte and ends the sector
   a_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_STATUS) |-> (rsp_byte_out == 8'd0 && rsp_last))
      else $error("malformed status result");

   // crc_ok only in a status result
   a_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_crc_ok) |-> (rsp_kind == KIND_STATUS))
      else $error("crc_ok outside status");

   // sector end only on a crc byte or status
   a_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> (rsp_kind == KIND_CRC || rsp_kind == KIND_STATUS))
      else $error("last on wrong kind");

endmodule

bind disk_sector_crc_scrambler dscs_checker u_dscs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_byte_out (rsp_byte_out),
   .rsp_kind     (rsp_kind),
   .rsp_crc_ok   (rsp_crc_ok),
   .rsp_last     (rsp_last)
);

### tb/testbench.sv
// self-checking testbench for the sector crc scrambler: directed and random sectors
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dscs_pkg::*;

   // sector geometry as the testbench sees it
   localparam int unsigned HEADER_LEN = 4;
   localparam int unsigned SD_LEN     = 128;
   localparam int unsigned DD_LEN     = 256;
   localparam logic [7:0]  XOR_MASK   = 8'hB3;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_R = 16'h8408;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned DECODE_DATA  = 40;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       ok;
      logic       last;
   } sector_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_first = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic [1:0]  rsp_kind;
   logic        rsp_crc_ok;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state and configuration copy
   logic [15:0] crc_acc = CRC_SEED;
   logic [8:0]  sector_pos = 9'd0;
   logic [7:0]  saved_crc_high = 8'h00;
   logic        cfg_decode = 1'b0;
   logic        cfg_double = 1'b1;

   sector_result_type pending_results[$];

   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned n_errors = 0;
   int unsigned n_items = 0;
   int unsigned n_results = 0;
   int unsigned n_sectors = 0;
   int unsigned n_crc_good = 0;
   int unsigned n_crc_bad = 0;

   disk_sector_crc_scrambler i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_byte_in  (req_byte_in),
      .req_first    (req_first),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_byte_out (rsp_byte_out),
      .rsp_kind     (rsp_kind),
      .rsp_crc_ok   (rsp_crc_ok),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #2 clock = ~clock;

   // bitwise reflected crc-16, one byte lsb first
   function automatic logic [15:0] crc16_mcrf(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void expect_result(logic [7:0] data, kind_type kind, logic ok, logic last);
      sector_result_type r;
      r.data = data;
      r.kind = kind;
      r.ok   = ok;
      r.last = last;
      pending_results.push_back(r);
   endfunction

   // advance the sector model by one accepted byte
   function automatic void predict_sector_byte(logic [7:0] b, logic first);
      logic [8:0] data_end;
      logic [7:0] plain;
      data_end = 9'(HEADER_LEN) + (cfg_double ? 9'(DD_LEN) : 9'(SD_LEN));
      if (first) begin
         crc_acc = CRC_SEED;
         sector_pos = 9'd0;
      end
      if (sector_pos < 9'(HEADER_LEN)) begin
         crc_acc = crc16_mcrf(crc_acc, b);
         sector_pos++;
         expect_result(b, KIND_HDR, 1'b0, 1'b0);
      end else if (sector_pos < data_end) begin
         plain = cfg_decode ? (b ^ XOR_MASK) : b;
         crc_acc = crc16_mcrf(crc_acc, plain);
         sector_pos++;
         expect_result(cfg_decode ? plain : (b ^ XOR_MASK), KIND_DATA, 1'b0, 1'b0);
         if (!cfg_decode && sector_pos == data_end) begin
            expect_result(crc_acc[15:8], KIND_CRC, 1'b0, 1'b0);
            expect_result(crc_acc[7:0], KIND_CRC, 1'b0, 1'b1);
         end
      end else if (cfg_decode) begin
         if (sector_pos == data_end) begin
            saved_crc_high = b;
            sector_pos++;
         end else if (sector_pos == data_end + 9'd1) begin
            sector_pos++;
            expect_result(8'h00, KIND_STATUS, {saved_crc_high, b} == crc_acc, 1'b1);
         end
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // result side: random stalls, compare each transaction with the oldest prediction
   always @(posedge clock) begin : result_checker
      sector_result_type want;
      if (rsp_pop && !rsp_empty) begin
         n_results++;
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, actual data %0h kind %0d",
                     $time, rsp_byte_out, rsp_kind);
         end else begin
            want = pending_results.pop_front();
            check_field("byte_out", want.data, rsp_byte_out);
            check_field("kind", want.kind, rsp_kind);
            check_field("crc_ok", want.ok, rsp_crc_ok);
            check_field("last", want.last, rsp_last);
            if (want.kind == KIND_STATUS) begin
               if (want.ok) n_crc_good++;
               else n_crc_bad++;
            end
         end
      end
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // one input transaction, with random sender gaps
   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_byte_in <= b;
      req_first   <= first;
      do @(posedge clock); while (req_full);
      predict_sector_byte(b, first);
      n_items++;
      if (first) n_sectors++;
   endtask

   // a run of random bytes, the first one optionally restarting the sector
   task automatic send_random(input int unsigned count, input logic restart);
      for (int unsigned i = 0; i < count; i++) begin
         send_byte(8'($urandom), restart && (i == 0));
      end
   endtask

   // stored crc from the predicted value, high byte first, optionally one bit broken
   task automatic send_crc(input bit bad_crc);
      logic [15:0] crc;
      int unsigned flip;
      crc = crc_acc;
      if (bad_crc) begin
         flip = $urandom_range(15);
         crc[flip] = ~crc[flip];
      end
      send_byte(crc[15:8], 1'b0);
      send_byte(crc[7:0], 1'b0);
   endtask

   // hold the sender until every predicted result is out and the pipe is empty
   task automatic settle();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_DIRECTION) cfg_decode = value;
      else cfg_double = value;
   endtask

   task automatic csr_read_check(input logic idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field(idx == REG_DIRECTION ? "direction" : "density",
                  {31'd0, idx == REG_DIRECTION ? cfg_decode : cfg_double}, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_mode(input logic decode, input logic double_density);
      settle();
      csr_write(REG_DIRECTION, decode);
      csr_write(REG_DENSITY, double_density);
   endtask

   // register access: reset values, both values of each register, readback
   task automatic test_registers();
      csr_read_check(REG_DIRECTION);
      csr_read_check(REG_DENSITY);
      csr_write(REG_DIRECTION, 1'b1);
      csr_write(REG_DENSITY, 1'b0);
      csr_read_check(REG_DIRECTION);
      csr_read_check(REG_DENSITY);
      csr_write(REG_DIRECTION, 1'b0);
      csr_write(REG_DENSITY, 1'b1);
      csr_read_check(REG_DIRECTION);
      csr_read_check(REG_DENSITY);
   endtask

   // header extremes and restarts, also in the middle of header and data
   task automatic test_header_restart();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hB3, 1'b0);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h3C, 1'b0);
   endtask

   // double density encode runs past the single density end with no crc bytes,
   // then the sector is closed as a single density decode with a matching crc
   task automatic test_density_switch_good_crc();
      send_idle_pct = 82;
      pop_stall_pct = 0;
      set_mode(1'b0, 1'b1);
      send_random(HEADER_LEN + SD_LEN, 1'b1);
      set_mode(1'b1, 1'b0);
      send_crc(1'b0);
      // past the sector end in decode, dropped
      send_byte(8'h77, 1'b0);
   endtask

   // decode data, then encode to the single density end with crc bytes,
   // a dropped byte, and a decode check against a broken crc
   task automatic test_encode_tail_bad_crc();
      send_idle_pct = 0;
      pop_stall_pct = 82;
      set_mode(1'b1, 1'b0);
      send_random(HEADER_LEN + DECODE_DATA, 1'b1);
      set_mode(1'b0, 1'b0);
      send_random(SD_LEN - DECODE_DATA, 1'b0);
      // past the sector end in encode, dropped
      send_byte(8'hFF, 1'b0);
      set_mode(1'b1, 1'b0);
      send_crc(1'b1);
   endtask

   // short random bursts under one idling setting
   task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned bursts);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      for (int unsigned s = 0; s < bursts; s++) begin
         set_mode(1'($urandom), 1'($urandom));
         send_random($urandom_range(4, 12), 1'b1);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_header_restart();
      test_density_switch_good_crc();
      test_encode_tail_bad_crc();
      test_random(30, 30, 3);

      // drain
      settle();
      if (pending_results.size() != 0) begin
         n_errors++;
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      end

      $display("covered %0d bytes in %0d sectors, %0d results checked", n_items, n_sectors,
               n_results);
      $display("crc status seen: %0d good, %0d bad; %0d mismatches", n_crc_good, n_crc_bad,
               n_errors);
      if (n_errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

endmodule

### files.f
rtl/dscs_pkg.sv
rtl/dscs_front.sv
rtl/dscs_queue.sv
rtl/dscs_back.sv
rtl/disk_sector_crc_scrambler.sv
rtl/dscs_checker.sv
tb/testbench.sv
